// File: sv/lsd_pkg.sv
`default_nettype none
package lsd_pkg;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int DIGITS_DEF    = 7;
    localparam int VALUE_W       = 24;
    localparam int RADIX         = 10;
    localparam int DIGIT_W       = 4;
    localparam int PASS_W        = 3;
    localparam int RECIP_W       = 29;
    localparam int PROD_W        = VALUE_W + RECIP_W;

    // Floor reciprocals of the powers of ten: for p > 0, (v * R) >> S is
    // floor(v / 10^p) or one below it; p = 0 bypasses the multiply in lsd_digit.
    localparam int DIV_SHIFT = 32;

    function automatic logic [RECIP_W-1:0] pow10_recip(input logic [PASS_W-1:0] p);
        logic [RECIP_W-1:0] r;
        begin
            unique case (p)
                3'd0:    r = 29'd0;
                3'd1:    r = 29'd429496729;
                3'd2:    r = 29'd42949672;
                3'd3:    r = 29'd4294967;
                3'd4:    r = 29'd429496;
                3'd5:    r = 29'd42949;
                3'd6:    r = 29'd4294;
                default: r = 29'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pow10_val(input logic [PASS_W-1:0] p);
        logic [VALUE_W-1:0] r;
        begin
            unique case (p)
                3'd0:    r = 24'd1;
                3'd1:    r = 24'd10;
                3'd2:    r = 24'd100;
                3'd3:    r = 24'd1000;
                3'd4:    r = 24'd10000;
                3'd5:    r = 24'd100000;
                3'd6:    r = 24'd1000000;
                default: r = 24'd1;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// File: sv/lsd_stream_if.sv
`default_nettype none
interface lsd_stream_if #(parameter int W = 25);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/lsd_radix_sort_base10.sv
// LSD radix sort, base 10.
// Input channel in: data = {last_in, value}. A value is stored in the cycle
// it is accepted, until an item with last_in set; that item starts the sort.
// Items beyond MAX_ITEMS are dropped, though a last flag still starts the sort.
// Output channel out: data = {last_out, sorted_value}, one item per stored
// value in ascending order of its low DIGITS decimal digits, last_out on
// the final one. The sort runs DIGITS passes over the n values; each pass
// has a count sweep (RAM read, multiply, quotient fix, digit through the
// shared digit unit), a bucket prefix, a scatter sweep and a copy back.
// Emission then reads the results from the item store in order.
// in.ready is low from the last item until the final result is loaded into
// the output register. The output is an item register: emission waits while
// out.ready is low and resumes when it rises.
// Reset clears counters and state; the stores need no clearing.
`default_nettype none
module lsd_radix_sort_base10 #(
    parameter int MAX_ITEMS = lsd_pkg::MAX_ITEMS_DEF,
    parameter int DIGITS    = lsd_pkg::DIGITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    lsd_stream_if.sink   in,
    lsd_stream_if.source out
);
    import lsd_pkg::*;
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [7:0] {
        S_LOAD  = 8'b00000001,
        S_COUNT = 8'b00000010,
        S_PREF  = 8'b00000100,
        S_SCAT  = 8'b00001000,
        S_COPY  = 8'b00010000,
        S_EMIT  = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_NEXT  = 8'b10000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [1:0]          ph_reg, ph_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic [CW-1:0]       bkt_reg [RADIX];
    logic [CW-1:0]       bkt_next [RADIX];
    logic [VALUE_W-1:0]  hold_reg, hold_next;
    logic [VALUE_W:0]    out_reg, out_next;
    logic                ov_reg, ov_next;

    logic                ia_we, sa_we;
    logic [AW-1:0]       ia_waddr, ia_raddr, sa_waddr, sa_raddr;
    logic [VALUE_W-1:0]  ia_wdata, ia_rdata, sa_rdata;
    logic [DIGIT_W-1:0]  digit;

    lsd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS), .AW(AW)) u_items (
        .clk(clk), .we(ia_we), .waddr(ia_waddr), .wdata(ia_wdata),
        .raddr(ia_raddr), .rdata(ia_rdata)
    );
    lsd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS), .AW(AW)) u_scratch (
        .clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(hold_reg),
        .raddr(sa_raddr), .rdata(sa_rdata)
    );
    lsd_digit u_digit (
        .clk(clk), .value(ia_rdata), .pass(pass_reg), .digit(digit)
    );

    assign in.ready  = (state_reg == S_LOAD);
    assign out.valid = ov_reg;
    assign out.data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ph_next    = ph_reg;
        pass_next  = pass_reg;
        bkt_next   = bkt_reg;
        hold_next  = hold_reg;
        out_next   = out_reg;
        ov_next    = ov_reg;
        ia_we      = 1'b0;
        sa_we      = 1'b0;
        ia_waddr   = AW'(count_reg);
        ia_wdata   = in.data[VALUE_W-1:0];
        ia_raddr   = AW'(idx_reg);
        sa_raddr   = AW'(idx_reg);
        sa_waddr   = AW'(bkt_reg[0]);
        if (ov_reg && out.ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_LOAD:
            begin
                if (in.valid)
                begin
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        ia_we      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (in.data[VALUE_W])
                    begin
                        idx_next  = '0;
                        ph_next   = '0;
                        pass_next = '0;
                        for (int k = 0; k < RADIX; k++)
                        begin
                            bkt_next[k] = '0;
                        end
                        if (count_next == '0)
                        begin
                            state_next = S_LOAD;
                        end
                        else
                        begin
                            state_next = S_COUNT;
                        end
                    end
                end
            end
            S_COUNT:
            begin
                // ph 0: read issued; 1: rdata, multiply; 2: quotient; 3: digit valid
                if (ph_reg == 2'd3)
                begin
                    bkt_next[digit] = bkt_reg[digit] + 1'b1;
                    ph_next = '0;
                    if (idx_reg + 1'b1 == count_reg)
                    begin
                        state_next = S_PREF;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    ph_next = ph_reg + 1'b1;
                end
            end
            S_PREF:
            begin
                bkt_next[0] = '0;
                for (int k = 1; k < RADIX; k++)
                begin
                    bkt_next[k] = bkt_next[k-1] + bkt_reg[k-1];
                end
                state_next = S_SCAT;
                ph_next    = '0;
            end
            S_SCAT:
            begin
                if (ph_reg == 2'd1)
                begin
                    hold_next = ia_rdata;
                end
                if (ph_reg == 2'd3)
                begin
                    sa_we    = 1'b1;
                    sa_waddr = AW'(bkt_reg[digit]);
                    bkt_next[digit] = bkt_reg[digit] + 1'b1;
                    ph_next = '0;
                    if (idx_reg + 1'b1 == count_reg)
                    begin
                        state_next = S_COPY;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    ph_next = ph_reg + 1'b1;
                end
            end
            S_COPY:
            begin
                if (ph_reg == 2'd1)
                begin
                    ia_we    = 1'b1;
                    ia_waddr = AW'(idx_reg);
                    ia_wdata = sa_rdata;
                    ph_next  = '0;
                    if (idx_reg + 1'b1 == count_reg)
                    begin
                        idx_next = '0;
                        for (int k = 0; k < RADIX; k++)
                        begin
                            bkt_next[k] = '0;
                        end
                        if (32'(pass_reg) + 1 >= DIGITS)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            pass_next  = pass_reg + 1'b1;
                            state_next = S_COUNT;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    ph_next = ph_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out.ready)
                begin
                    ov_next  = 1'b1;
                    out_next = {(idx_reg + 1'b1 == count_reg), ia_rdata};
                    if (idx_reg + 1'b1 == count_reg)
                    begin
                        count_next = '0;
                        idx_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_NEXT;
                    end
                end
            end
            S_NEXT:
            begin
                state_next = S_OUT;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            idx_reg   <= '0;
            ph_reg    <= '0;
            pass_reg  <= '0;
            ov_reg    <= 1'b0;
            for (int k = 0; k < RADIX; k++)
            begin
                bkt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            ph_reg    <= ph_next;
            pass_reg  <= pass_next;
            ov_reg    <= ov_next;
            bkt_reg   <= bkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end
endmodule
`default_nettype wire

// File: sv/lsd_ram.sv
`default_nettype none
module lsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: sv/lsd_digit.sv
`default_nettype none
module lsd_digit (
    input  wire logic                           clk,
    input  wire logic [lsd_pkg::VALUE_W-1:0]    value,
    input  wire logic [lsd_pkg::PASS_W-1:0]     pass,
    output logic      [lsd_pkg::DIGIT_W-1:0]    digit
);
    import lsd_pkg::*;
    // Reciprocal multiply and quotient fix are registered; mod 10 is combinational.
    logic [PROD_W-1:0]  prod_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [PASS_W-1:0]  pass_reg;
    logic [VALUE_W-1:0] q_reg;
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] rem;
    logic [PROD_W-1:0]  qx;
    logic [VALUE_W-1:0] q10;
    logic [VALUE_W-1:0] r10;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(value) * PROD_W'(pow10_recip(pass));
        val_reg  <= value;
        pass_reg <= pass;
        q_reg    <= q;
    end

    always_comb
    begin
        q   = (pass_reg == '0) ? val_reg : VALUE_W'(prod_reg >> DIV_SHIFT);
        rem = val_reg - VALUE_W'(q * pow10_val(pass_reg));
        if (rem >= pow10_val(pass_reg))
        begin
            q = q + 1'b1;
        end
    end

    always_comb
    begin
        qx  = PROD_W'(q_reg) * PROD_W'(pow10_recip(3'd1));
        q10 = VALUE_W'(qx >> DIV_SHIFT);
        r10 = q_reg - VALUE_W'(q10 * VALUE_W'(RADIX));
        if (r10 >= VALUE_W'(RADIX))
        begin
            r10 = r10 - VALUE_W'(RADIX);
        end
        digit = DIGIT_W'(r10);
    end
endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import lsd_pkg::*;

    localparam int NMAX = MAX_ITEMS_DEF;
    localparam int LIMIT = 3000000;
    localparam int NUM_ITEMS = 420;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               last;
    } item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lsd_stream_if #(.W(VALUE_W + 1)) in_ch ();
    lsd_stream_if #(.W(VALUE_W + 1)) out_ch ();

    lsd_radix_sort_base10 DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in(in_ch.sink),
        .out(out_ch.source)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [VALUE_W-1:0] held_values[$];
    item_t sorted_expect[$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int runs_done = 0;
    int cycles = 0;
    bit stim_done = 0;
    bit hold_off = 0;
    logic [VALUE_W-1:0] seen_value;
    logic seen_last;

    task automatic report(input string what);
        errors++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    function automatic int digit_at(input logic [VALUE_W-1:0] v, input int p);
        int unsigned d;
        d = 32'(v);
        for (int i = 0; i < p; i++)
            d = d / 10;
        return d % 10;
    endfunction

    // stable LSD sort of the held set, queued as expected output
    task automatic predict_sorted_run();
        logic [VALUE_W-1:0] cur[$];
        logic [VALUE_W-1:0] nxt[$];
        item_t it;
        cur = held_values;
        for (int p = 0; p < DIGITS_DEF; p++)
        begin
            nxt = {};
            for (int b = 0; b < RADIX; b++)
                foreach (cur[j])
                    if (digit_at(cur[j], p) == b)
                        nxt = {nxt, cur[j]};
            cur = nxt;
        end
        foreach (cur[j])
        begin
            it.value = cur[j];
            it.last = (j == cur.size() - 1);
            sorted_expect = {sorted_expect, it};
        end
        held_values = {};
    endtask

    task automatic accept_item(input item_t it);
        if (held_values.size() < NMAX)
            held_values = {held_values, it.value};
        if (it.last)
            predict_sorted_run();
    endtask

    // starts and ends at a falling edge; valid is left high on return
    task automatic send_item(input logic [VALUE_W-1:0] v, input logic l);
        item_t it;
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {l, v};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        it.value = v;
        it.last = l;
        accept_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return VALUE_W'($urandom_range(0, 9));
            1: return VALUE_W'($urandom_range(0, 9999999));
            2: return VALUE_W'($urandom_range(9999990, 9999999));
            3: return VALUE_W'($urandom);
            default: return VALUE_W'($urandom_range(0, 999));
        endcase
    endfunction

    // directed rows: {value, last, check the run's final result, its value}
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               chk;
        logic [VALUE_W-1:0] expv;
    } row_t;
    row_t directed[] = '{
        '{24'd0, 1'b1, 1'b1, 24'd0},
        '{24'd9999999, 1'b1, 1'b1, 24'd9999999},
        '{24'd9999999, 1'b0, 1'b0, 24'd0}, '{24'd0, 1'b0, 1'b0, 24'd0},
        '{24'd5, 1'b0, 1'b0, 24'd0}, '{24'd5, 1'b1, 1'b1, 24'd9999999},
        '{24'hFFFFFF, 1'b0, 1'b0, 24'd0}, '{24'd6777216, 1'b0, 1'b0, 24'd0},
        '{24'd16777215, 1'b0, 1'b0, 24'd0}, '{24'd10000000, 1'b0, 1'b0, 24'd0},
        '{24'd3, 1'b1, 1'b0, 24'd0},
        '{24'd1000000, 1'b0, 1'b0, 24'd0}, '{24'd100, 1'b0, 1'b0, 24'd0},
        '{24'd10, 1'b0, 1'b0, 24'd0}, '{24'd1, 1'b1, 1'b0, 24'd0},
        '{24'hAAAAAA, 1'b0, 1'b0, 24'd0}, '{24'h555555, 1'b1, 1'b0, 24'd0}
    };

    initial
    begin
        int n;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (directed[i])
        begin
            send_item(directed[i].value, directed[i].last);
            if (directed[i].chk)
            begin
                in_ch.valid <= 1'b0;
                wait (sorted_expect.size() == 0);
                @(negedge clk);
                if (seen_value !== directed[i].expv || seen_last !== 1'b1)
                    report($sformatf("run end %0d/%b, expected %0d/1",
                                     seen_value, seen_last, directed[i].expv));
            end
        end
        // store overflow: 70 values, those beyond 64 dropped; the last still starts the sort
        for (int i = 0; i < 70; i++)
            send_item(rand_value(), i == 69);
        hold_off = 1;
        for (int i = 0; i < 64; i++)
            send_item(rand_value(), i == 63);
        send_item(24'd7, 1'b1);
        while (items_sent < NUM_ITEMS)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 68)
                                            : $urandom_range(1, 12);
            if (n > NUM_ITEMS - items_sent)
                n = NUM_ITEMS - items_sent;
            for (int i = 0; i < n; i++)
                send_item(rand_value(), i == n - 1);
        end
        in_ch.valid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        bit held;
        held = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off && !held && out_ch.valid)
            begin
                held = 1;
                out_ch.ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            out_ch.ready <= ($urandom_range(0, 6) == 0) ? 1'b1 :
                            ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        item_t exp_item;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            seen_value = out_ch.data[VALUE_W-1:0];
            seen_last = out_ch.data[VALUE_W];
            if (sorted_expect.size() == 0)
                report($sformatf("unexpected result %0d", out_ch.data[VALUE_W-1:0]));
            else
            begin
                exp_item = sorted_expect.pop_front();
                if (out_ch.data[VALUE_W-1:0] !== exp_item.value)
                    report($sformatf("sorted_value %0d, expected %0d",
                                     out_ch.data[VALUE_W-1:0], exp_item.value));
                if (out_ch.data[VALUE_W] !== exp_item.last)
                    report($sformatf("last_out %b, expected %b",
                                     out_ch.data[VALUE_W], exp_item.last));
                if (exp_item.last)
                    runs_done++;
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (!(stim_done && sorted_expect.size() == 0) && cycles < LIMIT)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (cycles >= LIMIT)
            $display("Simulation FAILED");
        else
        begin
            $display("Sent %0d values in %0d sets, %0d sorted values checked.",
                     items_sent, runs_done, results_seen);
            if (errors == 0 && sorted_expect.size() == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
        end
        $finish;
    end

    always @(posedge clk)
        cycles <= cycles + 1;
endmodule
